### src/mcclip_pkg.sv
// Shared widths, codes and item types for the moving circle collision clip block.
package mcclip_pkg;

	localparam int CW        = 32;   // coordinate and move width, Q16.16
	localparam int RW        = 31;   // radius width
	localparam int DW        = CW + 1;
	localparam int A_W       = 2 * CW + 1;
	localparam int B_W       = 2 * CW + 3;
	localparam int C_W       = 2 * CW + 2;
	localparam int ABSB_W    = B_W - 1;
	localparam int ABSC_W    = C_W - 1;
	localparam int NUM_W     = 2 * CW + 5;
	localparam int DEN_W     = 2 * CW + 2;
	localparam int DELTA_W   = 4 * CW + 5;
	localparam int SQ_W      = DELTA_W + 1;
	localparam int ROOT_W    = SQ_W / 2;
	localparam int REM_W     = ROOT_W + 1;
	localparam int CHUNK_W   = 22;
	localparam int NCHUNK    = 3;
	localparam int PP_W      = 2 * CHUNK_W;
	localparam int ROW_W     = PP_W + 2 * CHUNK_W + 1;
	localparam int SUM_W     = SQ_W;
	localparam int BB_W      = 2 * ABSB_W;
	localparam int AC_W      = A_W + ABSC_W;
	localparam int MPP_W     = CW + CHUNK_W;
	localparam int PROD_W    = CW + DEN_W - 1;
	localparam int DIV_N     = CW;
	localparam int DREM_W    = DEN_W;
	localparam int IN_W      = 320;
	localparam int OUT_W     = 4 * CW;
	localparam int EPS_W     = 32;
	localparam logic [EPS_W-1:0] EPS_RESET = 32'd42950;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int QCNT_W    = 3;

	// item classes decided in the front part
	localparam logic [1:0] K_PASS  = 2'd0;   // no hit, moves pass through
	localparam logic [1:0] K_STOP  = 2'd1;   // touching and closing, moves zeroed
	localparam logic [1:0] K_SOLVE = 2'd2;   // time of impact from num/den

	typedef logic [3:0][CW-1:0] mv_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic [DELTA_W-1:0]       delta;
		logic signed [NUM_W-1:0]  num_pre;
		logic [DEN_W-1:0]         den;
		mv_t                      mv;
	} fe_item_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [NUM_W-1:0]  num_pre;
		logic [DEN_W-1:0]         den;
		mv_t                      mv;
	} bk_pay_t;

endpackage

### src/mcclip_front.sv
// Front part: forms a, b, c and the discriminant, classifies each pair.
module mcclip_front import mcclip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [EPS_W-1:0]  eps,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [IN_W-1:0]   in_data,
	output logic              push_valid,
	input  logic              push_ready,
	output fe_item_t          push_item
);

	logic [8:1] vld_s;
	logic       en;

	assign en         = !vld_s[8] || push_ready;
	assign in_ready   = en;
	assign push_valid = vld_s[8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[7:1], in_valid};
		end
	end

	// unpack
	logic [CW-1:0] p1x, p1y, p2x, p2y;
	logic [RW-1:0] r1, r2;
	mv_t           mv_in;
	assign p1x = in_data[0*CW +: CW];
	assign p1y = in_data[1*CW +: CW];
	assign p2x = in_data[2*CW +: CW];
	assign p2y = in_data[3*CW +: CW];
	assign mv_in[0] = in_data[4*CW +: CW];
	assign mv_in[1] = in_data[5*CW +: CW];
	assign mv_in[2] = in_data[6*CW +: CW];
	assign mv_in[3] = in_data[7*CW +: CW];
	assign r1 = in_data[8*CW +: RW];
	assign r2 = in_data[8*CW+RW +: RW];

	// stage 1: differences
	logic signed [DW-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [CW-1:0]        rs_s1;
	mv_t                  mv_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= $signed({p1x[CW-1], p1x}) - $signed({p2x[CW-1], p2x});
			dy_s1  <= $signed({p1y[CW-1], p1y}) - $signed({p2y[CW-1], p2y});
			dvx_s1 <= $signed({mv_in[0][CW-1], mv_in[0]}) - $signed({mv_in[2][CW-1], mv_in[2]});
			dvy_s1 <= $signed({mv_in[1][CW-1], mv_in[1]}) - $signed({mv_in[3][CW-1], mv_in[3]});
			rs_s1  <= {1'b0, r1} + {1'b0, r2};
			mv_s1  <= mv_in;
		end
	end

	// stage 2: squares and dot products
	logic signed [2*DW-1:0] pvx_s2, pvy_s2, pxv_s2, pyv_s2, pxx_s2, pyy_s2;
	logic [2*CW-1:0]        prr_s2;
	mv_t                    mv_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			pvx_s2 <= dvx_s1 * dvx_s1;
			pvy_s2 <= dvy_s1 * dvy_s1;
			pxv_s2 <= dx_s1 * dvx_s1;
			pyv_s2 <= dy_s1 * dvy_s1;
			pxx_s2 <= dx_s1 * dx_s1;
			pyy_s2 <= dy_s1 * dy_s1;
			prr_s2 <= rs_s1 * rs_s1;
			mv_s2  <= mv_s1;
		end
	end

	// stage 3: a, b, c
	logic [A_W-1:0]         a_s3;
	logic signed [B_W-1:0]  b_s3;
	logic signed [C_W-1:0]  c_s3;
	logic signed [B_W-1:0]  bsum;
	mv_t                    mv_s3;
	assign bsum = B_W'(pxv_s2) + B_W'(pyv_s2);
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3  <= {1'b0, pvx_s2[2*CW-1:0]} + {1'b0, pvy_s2[2*CW-1:0]};
			b_s3  <= {bsum[B_W-2:0], 1'b0};
			c_s3  <= {2'b00, pxx_s2[2*CW-1:0]} + {2'b00, pyy_s2[2*CW-1:0]}
				- {2'b00, prr_s2};
			mv_s3 <= mv_s2;
		end
	end

	// stage 4: classify
	logic [ABSB_W-1:0]      abs_b;
	logic [ABSC_W-1:0]      abs_c;
	logic                   b_neg, c_neg, small_a, b_small, c_le;
	logic [B_W-1:0]         nb;
	logic [C_W-1:0]         nc;
	logic [1:0]             kind_c;
	logic                   gen_c;
	logic signed [NUM_W-1:0] num_c;
	logic [DEN_W-1:0]       den_c;

	always_comb begin
		b_neg   = b_s3[B_W-1];
		c_neg   = c_s3[C_W-1];
		nb      = -b_s3;
		nc      = -c_s3;
		abs_b   = b_neg ? nb[ABSB_W-1:0] : b_s3[ABSB_W-1:0];
		abs_c   = c_neg ? nc[ABSC_W-1:0] : c_s3[ABSC_W-1:0];
		small_a = a_s3 <= A_W'(eps);
		b_small = abs_b <= ABSB_W'(eps);
		c_le    = c_neg || (c_s3[C_W-2:0] <= (C_W-1)'(eps));
		priority if (small_a) begin
			gen_c  = 1'b0;
			kind_c = b_small ? K_PASS : K_SOLVE;
			num_c  = b_neg ? NUM_W'(c_s3) : -NUM_W'(c_s3);
			den_c  = abs_b;
		end else if (c_le && b_neg) begin
			gen_c  = 1'b0;
			kind_c = K_STOP;
			num_c  = '0;
			den_c  = '0;
		end else begin
			gen_c  = 1'b1;
			kind_c = K_SOLVE;
			num_c  = -NUM_W'(b_s3);
			den_c  = {a_s3, 1'b0};
		end
	end

	logic [1:0]              kind_s4;
	logic                    gen_s4, c_neg_s4;
	logic signed [NUM_W-1:0] num_s4;
	logic [DEN_W-1:0]        den_s4;
	logic [ABSB_W-1:0]       abs_b_s4;
	logic [A_W-1:0]          a_s4;
	logic [ABSC_W-1:0]       abs_c_s4;
	mv_t                     mv_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4  <= kind_c;
			gen_s4   <= gen_c;
			c_neg_s4 <= c_neg;
			num_s4   <= num_c;
			den_s4   <= den_c;
			abs_b_s4 <= abs_b;
			a_s4     <= a_s3;
			abs_c_s4 <= abs_c;
			mv_s4    <= mv_s3;
		end
	end

	// stage 5: partial products of b*b and a*|c|
	logic [NCHUNK*CHUNK_W-1:0] bw, aw, cw;
	assign bw = (NCHUNK*CHUNK_W)'(abs_b_s4);
	assign aw = (NCHUNK*CHUNK_W)'(a_s4);
	assign cw = (NCHUNK*CHUNK_W)'(abs_c_s4);

	logic [PP_W-1:0]         bb_pp_s5 [NCHUNK][NCHUNK];
	logic [PP_W-1:0]         ac_pp_s5 [NCHUNK][NCHUNK];
	logic [1:0]              kind_s5;
	logic                    gen_s5, c_neg_s5;
	logic signed [NUM_W-1:0] num_s5;
	logic [DEN_W-1:0]        den_s5;
	mv_t                     mv_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCHUNK; i++) begin
				for (int j = 0; j < NCHUNK; j++) begin
					bb_pp_s5[i][j] <= bw[i*CHUNK_W +: CHUNK_W] * bw[j*CHUNK_W +: CHUNK_W];
					ac_pp_s5[i][j] <= aw[i*CHUNK_W +: CHUNK_W] * cw[j*CHUNK_W +: CHUNK_W];
				end
			end
			kind_s5  <= kind_s4;
			gen_s5   <= gen_s4;
			c_neg_s5 <= c_neg_s4;
			num_s5   <= num_s4;
			den_s5   <= den_s4;
			mv_s5    <= mv_s4;
		end
	end

	// stage 6: row sums
	logic [ROW_W-1:0]        bb_row_s6 [NCHUNK];
	logic [ROW_W-1:0]        ac_row_s6 [NCHUNK];
	logic [1:0]              kind_s6;
	logic                    gen_s6, c_neg_s6;
	logic signed [NUM_W-1:0] num_s6;
	logic [DEN_W-1:0]        den_s6;
	mv_t                     mv_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCHUNK; i++) begin
				bb_row_s6[i] <= ROW_W'(bb_pp_s5[i][0])
					+ (ROW_W'(bb_pp_s5[i][1]) << CHUNK_W)
					+ (ROW_W'(bb_pp_s5[i][2]) << (2 * CHUNK_W));
				ac_row_s6[i] <= ROW_W'(ac_pp_s5[i][0])
					+ (ROW_W'(ac_pp_s5[i][1]) << CHUNK_W)
					+ (ROW_W'(ac_pp_s5[i][2]) << (2 * CHUNK_W));
			end
			kind_s6  <= kind_s5;
			gen_s6   <= gen_s5;
			c_neg_s6 <= c_neg_s5;
			num_s6   <= num_s5;
			den_s6   <= den_s5;
			mv_s6    <= mv_s5;
		end
	end

	// stage 7: full products
	logic [SUM_W-1:0]        bb_sum, ac_sum;
	assign bb_sum = SUM_W'(bb_row_s6[0]) + (SUM_W'(bb_row_s6[1]) << CHUNK_W)
		+ (SUM_W'(bb_row_s6[2]) << (2 * CHUNK_W));
	assign ac_sum = SUM_W'(ac_row_s6[0]) + (SUM_W'(ac_row_s6[1]) << CHUNK_W)
		+ (SUM_W'(ac_row_s6[2]) << (2 * CHUNK_W));

	logic [BB_W-1:0]         bb_s7;
	logic [AC_W-1:0]         ac_s7;
	logic [1:0]              kind_s7;
	logic                    gen_s7, c_neg_s7;
	logic signed [NUM_W-1:0] num_s7;
	logic [DEN_W-1:0]        den_s7;
	mv_t                     mv_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			bb_s7    <= bb_sum[BB_W-1:0];
			ac_s7    <= ac_sum[AC_W-1:0];
			kind_s7  <= kind_s6;
			gen_s7   <= gen_s6;
			c_neg_s7 <= c_neg_s6;
			num_s7   <= num_s6;
			den_s7   <= den_s6;
			mv_s7    <= mv_s6;
		end
	end

	// stage 8: discriminant; a negative one in the general case means no hit
	logic [SQ_W-1:0] bb_x, ac4_x, delta_w;
	logic            d_neg;
	assign bb_x    = SQ_W'(bb_s7);
	assign ac4_x   = {SQ_W'(ac_s7)} << 2;
	assign delta_w = c_neg_s7 ? bb_x + ac4_x : bb_x - ac4_x;
	assign d_neg   = delta_w[SQ_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			push_item.kind    <= (gen_s7 && d_neg) ? K_PASS : kind_s7;
			push_item.delta   <= (gen_s7 && !d_neg) ? delta_w[DELTA_W-1:0] : '0;
			push_item.num_pre <= num_s7;
			push_item.den     <= den_s7;
			push_item.mv      <= mv_s7;
		end
	end

endmodule

### src/mcclip_queue.sv
// Short queue between the front and back parts.
module mcclip_queue import mcclip_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  fe_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output fe_item_t  out_item
);

	fe_item_t          mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push, pop;

	assign in_ready  = cnt_q != QCNT_W'(QDEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	a_ptr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		QPTR_W'(rd_q + cnt_q[QPTR_W-1:0]) == wr_q)
		else $error("queue pointers and count disagree");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance on push");

endmodule

### src/mcclip_back.sv
// Back part: square root, time of impact check and scaling of the moves.
module mcclip_back import mcclip_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  fe_item_t  pop_item,
	output logic      out_valid,
	input  logic      out_ready,
	output logic      out_hit,
	output mv_t       out_mv
);

	logic en;
	logic out_vld_q, out_hit_q;
	mv_t  out_mv_q;

	assign en        = !out_vld_q || out_ready;
	assign pop_ready = en;
	assign out_valid = out_vld_q;
	assign out_hit   = out_hit_q;
	assign out_mv    = out_mv_q;

	// square root, one result bit a stage
	logic                sq_vld_s  [1:ROOT_W];
	logic [SQ_W-1:0]     sq_x_s    [1:ROOT_W];
	logic [REM_W-1:0]    sq_rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0]   sq_root_s [1:ROOT_W];
	bk_pay_t             sq_pay_s  [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
		logic              cur_vld;
		logic [SQ_W-1:0]   cur_x;
		logic [REM_W-1:0]  cur_rem;
		logic [ROOT_W-1:0] cur_root;
		bk_pay_t           cur_pay;
		logic [REM_W+1:0]  rem_w, trial_w, diff_w;

		if (k == 0) begin : g_in
			assign cur_vld  = pop_valid;
			assign cur_x    = {1'b0, pop_item.delta};
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_pay  = '{kind: pop_item.kind, num_pre: pop_item.num_pre,
				den: pop_item.den, mv: pop_item.mv};
		end else begin : g_reg
			assign cur_vld  = sq_vld_s[k];
			assign cur_x    = sq_x_s[k];
			assign cur_rem  = sq_rem_s[k];
			assign cur_root = sq_root_s[k];
			assign cur_pay  = sq_pay_s[k];
		end

		assign rem_w   = {cur_rem, cur_x[SQ_W-1 -: 2]};
		assign trial_w = {1'b0, cur_root, 2'b01};
		assign diff_w  = rem_w - trial_w;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_w >= trial_w) begin
					sq_rem_s[k+1]  <= diff_w[REM_W-1:0];
					sq_root_s[k+1] <= {cur_root[ROOT_W-2:0], 1'b1};
				end else begin
					sq_rem_s[k+1]  <= rem_w[REM_W-1:0];
					sq_root_s[k+1] <= {cur_root[ROOT_W-2:0], 1'b0};
				end
				sq_x_s[k+1]   <= {cur_x[SQ_W-3:0], 2'b00};
				sq_pay_s[k+1] <= cur_pay;
			end
		end
	end

	// numerator and the open interval check
	bk_pay_t                 sq_end;
	logic signed [NUM_W-1:0] num_w;
	logic                    clip_w;
	assign sq_end = sq_pay_s[ROOT_W];
	assign num_w  = sq_end.num_pre - $signed({2'b00, sq_root_s[ROOT_W]});
	assign clip_w = (sq_end.kind == K_SOLVE) && (num_w > 0)
		&& (num_w < $signed({3'b000, sq_end.den}));

	logic             cl_vld_s68, cl_clip_s68, cl_stop_s68;
	logic [DEN_W-1:0] cl_num_s68, cl_den_s68;
	mv_t              cl_mv_s68;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cl_vld_s68 <= 1'b0;
		end else if (en) begin
			cl_vld_s68 <= sq_vld_s[ROOT_W];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cl_clip_s68 <= clip_w;
			cl_stop_s68 <= sq_end.kind == K_STOP;
			cl_num_s68  <= num_w[DEN_W-1:0];
			cl_den_s68  <= sq_end.den;
			cl_mv_s68   <= sq_end.mv;
		end
	end

	// |move| * num as partial products, then summed
	logic [MPP_W-1:0] mu_pp_s69 [4][NCHUNK];
	logic [3:0]       mu_neg_s69;
	logic             mu_vld_s69, mu_clip_s69, mu_stop_s69;
	logic [DEN_W-1:0] mu_den_s69;
	mv_t              mu_mv_s69;
	logic [CW-1:0]    mag [4];
	logic [NCHUNK*CHUNK_W-1:0] numw;
	assign numw = (NCHUNK*CHUNK_W)'(cl_num_s68);
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			mag[l] = cl_mv_s68[l][CW-1] ? -cl_mv_s68[l] : cl_mv_s68[l];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_vld_s69 <= 1'b0;
		end else if (en) begin
			mu_vld_s69 <= cl_vld_s68;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				for (int j = 0; j < NCHUNK; j++) begin
					mu_pp_s69[l][j] <= mag[l] * numw[j*CHUNK_W +: CHUNK_W];
				end
				mu_neg_s69[l] <= cl_mv_s68[l][CW-1];
			end
			mu_clip_s69 <= cl_clip_s68;
			mu_stop_s69 <= cl_stop_s68;
			mu_den_s69  <= cl_den_s68;
			mu_mv_s69   <= cl_mv_s68;
		end
	end

	logic [PROD_W-1:0] pr_p_s70 [4];
	logic [3:0]        pr_neg_s70;
	logic              pr_vld_s70, pr_clip_s70, pr_stop_s70;
	logic [DEN_W-1:0]  pr_den_s70;
	mv_t               pr_mv_s70;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_vld_s70 <= 1'b0;
		end else if (en) begin
			pr_vld_s70 <= mu_vld_s69;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				pr_p_s70[l] <= PROD_W'(mu_pp_s69[l][0])
					+ (PROD_W'(mu_pp_s69[l][1]) << CHUNK_W)
					+ (PROD_W'(mu_pp_s69[l][2]) << (2 * CHUNK_W));
			end
			pr_neg_s70  <= mu_neg_s69;
			pr_clip_s70 <= mu_clip_s69;
			pr_stop_s70 <= mu_stop_s69;
			pr_den_s70  <= mu_den_s69;
			pr_mv_s70   <= mu_mv_s69;
		end
	end

	// restoring division by den, one quotient bit a stage; the quotient fits CW bits
	logic              dv_vld_s  [1:DIV_N];
	logic              dv_clip_s [1:DIV_N];
	logic              dv_stop_s [1:DIV_N];
	logic [3:0]        dv_neg_s  [1:DIV_N];
	logic [DEN_W-1:0]  dv_den_s  [1:DIV_N];
	mv_t               dv_mv_s   [1:DIV_N];
	logic [DREM_W-1:0] dv_rem_s  [4][1:DIV_N];
	logic [CW-1:0]     dv_low_s  [4][1:DIV_N];
	logic [CW-1:0]     dv_q_s    [4][1:DIV_N];

	for (genvar k = 0; k < DIV_N; k++) begin : g_dv
		logic             c_vld, c_clip, c_stop;
		logic [3:0]       c_neg;
		logic [DEN_W-1:0] c_den;
		mv_t              c_mv;

		if (k == 0) begin : g_in
			assign c_vld  = pr_vld_s70;
			assign c_clip = pr_clip_s70;
			assign c_stop = pr_stop_s70;
			assign c_neg  = pr_neg_s70;
			assign c_den  = pr_den_s70;
			assign c_mv   = pr_mv_s70;
		end else begin : g_reg
			assign c_vld  = dv_vld_s[k];
			assign c_clip = dv_clip_s[k];
			assign c_stop = dv_stop_s[k];
			assign c_neg  = dv_neg_s[k];
			assign c_den  = dv_den_s[k];
			assign c_mv   = dv_mv_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k+1] <= c_vld;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_clip_s[k+1] <= c_clip;
				dv_stop_s[k+1] <= c_stop;
				dv_neg_s[k+1]  <= c_neg;
				dv_den_s[k+1]  <= c_den;
				dv_mv_s[k+1]   <= c_mv;
			end
		end

		for (genvar l = 0; l < 4; l++) begin : g_lane
			logic [DREM_W-1:0] c_rem;
			logic [CW-1:0]     c_low, c_q;
			logic [DREM_W:0]   cur, diff;
			logic              ge;

			if (k == 0) begin : g_in
				assign c_rem = {1'b0, pr_p_s70[l][PROD_W-1:CW]};
				assign c_low = pr_p_s70[l][CW-1:0];
				assign c_q   = '0;
			end else begin : g_reg
				assign c_rem = dv_rem_s[l][k];
				assign c_low = dv_low_s[l][k];
				assign c_q   = dv_q_s[l][k];
			end

			assign cur  = {c_rem, c_low[CW-1]};
			assign ge   = cur >= {1'b0, c_den};
			assign diff = cur - {1'b0, c_den};

			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[l][k+1] <= ge ? diff[DREM_W-1:0] : cur[DREM_W-1:0];
					dv_low_s[l][k+1] <= {c_low[CW-2:0], 1'b0};
					dv_q_s[l][k+1]   <= {c_q[CW-2:0], ge};
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld_s[DIV_N];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_hit_q <= dv_clip_s[DIV_N] || dv_stop_s[DIV_N];
			for (int l = 0; l < 4; l++) begin
				priority if (dv_clip_s[DIV_N]) begin
					out_mv_q[l] <= dv_neg_s[DIV_N][l] ? -dv_q_s[l][DIV_N] : dv_q_s[l][DIV_N];
				end else if (dv_stop_s[DIV_N]) begin
					out_mv_q[l] <= '0;
				end else begin
					out_mv_q[l] <= dv_mv_s[DIV_N][l];
				end
			end
		end
	end

	a_no_root_input: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_item.kind != K_SOLVE) |-> pop_item.delta == '0)
		else $error("discriminant present on an item that takes no root");

	a_clip_stop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cl_vld_s68 |-> !(cl_clip_s68 && cl_stop_s68))
		else $error("item both clipped and stopped");

endmodule

### src/moving_circle_collision_clip.sv
// Top level of the moving circle collision clip block.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: pos1/2, move1/2, radius1/2
//  m_*       out  m_tvalid/m_tready  m_tdata: out1_x..out2_y, m_tuser: hit
//  eps_*     in   eps_we             eps_wdata: epsilon, Q0.32 threshold
//
// One pair enters per cycle while s_tready is high. From s_tdata to m_tdata
// an item passes 8 front stages (products, discriminant), the queue, 67
// square root stages, 3 stages for the interval check and the products, 32
// divider stages and the output register. The square root and the divider
// each retire one bit a stage, which sets the depth.
// Reset clears every valid flag and the queue, and loads epsilon with 42950.
// A stall on m_tready freezes the back part; the front keeps running until
// the four-entry queue fills, then drops s_tready.
module moving_circle_collision_clip import mcclip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// pos1_x, pos1_y, pos2_x, pos2_y, move1_x, move1_y, move2_x, move2_y,
	// radius1, radius2, two zero bits
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// out1_x, out1_y, out2_x, out2_y
	output logic [OUT_W-1:0]  m_tdata,
	// hit
	output logic [0:0]        m_tuser,
	input  logic              eps_we,
	input  logic [EPS_W-1:0]  eps_wdata
);

	logic [EPS_W-1:0] eps_q;

	// hold the threshold; write it only while the block is idle (the block does not enforce this)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (eps_we) begin
			eps_q <= eps_wdata;
		end
	end

	fe_item_t fq_item, qb_item;
	logic     fq_valid, fq_ready, qb_valid, qb_ready;
	logic     hit;
	mv_t      mv_out;

	mcclip_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.eps        (eps_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item)
	);

	// decouple classification from the long root and divide pipelines
	mcclip_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	mcclip_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_item  (qb_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_hit   (hit),
		.out_mv    (mv_out)
	);

	assign m_tdata = mv_out;
	assign m_tuser = hit;

endmodule
